FILE: src/mngd_pkg.sv
// Package for the MIDI note gate decoder: parse phase type, message codes
// and the result struct passed from the parser to the output stage.
// No dependencies.
package mngd_pkg;

  // Parser phase. Code 3 is never entered and behaves like waiting.
  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } mngd_phase_t;

  // Status high nibbles that the decoder acts on.
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;

  typedef struct packed {
    logic [5:0] note_code;
    logic       note_strobe;
    logic       gate_level;
    logic       led_level;
  } mngd_result_t;

endpackage

FILE: src/mngd_parser.sv
// MIDI byte parser and note/gate state for the note gate decoder.
// Depends on mngd_pkg.
module mngd_parser
  import mngd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output mngd_result_t result
);

  mngd_phase_t phase_r, phase_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [6:0]  first_r, first_nxt;
  logic [6:0]  held_r, held_nxt;
  logic [5:0]  latch_r, latch_nxt;
  logic        gate_r, gate_nxt;
  logic        led_r, led_nxt;
  logic        strobe;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    first_nxt = first_r;
    held_nxt  = held_r;
    latch_nxt = latch_r;
    gate_nxt  = gate_r;
    led_nxt   = led_r;
    strobe    = 1'b0;
    if (rx_byte[7]) begin
      // A status byte always restarts the message, dropping any partial one.
      kind_nxt  = rx_byte[7:4];
      phase_nxt = PH_FIRST;
    end else begin
      unique case (phase_r)
        PH_FIRST: begin
          first_nxt = rx_byte[6:0];
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          phase_nxt = PH_WAIT;
          if (kind_r == MSG_NOTE_ON) begin
            latch_nxt = first_r[5:0];
            held_nxt  = first_r;
            strobe    = 1'b1;
            gate_nxt  = 1'b1;
            led_nxt   = 1'b1;
          end else if (kind_r == MSG_NOTE_OFF && first_r == held_r) begin
            gate_nxt = 1'b0;
            led_nxt  = 1'b0;
          end
        end
        default: begin
          // Waiting: data bytes are ignored.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      kind_r  <= '0;
      first_r <= '0;
      held_r  <= '0;
      latch_r <= '0;
      gate_r  <= 1'b0;
      led_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      first_r <= first_nxt;
      held_r  <= held_nxt;
      latch_r <= latch_nxt;
      gate_r  <= gate_nxt;
      led_r   <= led_nxt;
    end
  end

  assign result.note_code   = latch_nxt;
  assign result.note_strobe = strobe;
  assign result.gate_level  = gate_nxt;
  assign result.led_level   = led_nxt;

`ifndef NO_ASSERTIONS
  a_led_follows_gate: assert property (@(posedge clk) disable iff (!rst_n)
    led_r == gate_r) else $error("LED and gate disagree");

  a_strobe_sets_gate: assert property (@(posedge clk) disable iff (!rst_n)
    step && strobe |=> gate_r && latch_r == $past(first_r[5:0]))
    else $error("note-on did not latch note and open gate");

  a_status_arms_first: assert property (@(posedge clk) disable iff (!rst_n)
    step && rx_byte[7] |=> phase_r == PH_FIRST)
    else $error("status byte did not arm first data phase");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(gate_r) && $stable(latch_r) && $stable(held_r))
    else $error("parser state moved without a step");
`endif

endmodule

FILE: src/midi_note_gate_decoder.sv
// MIDI note gate decoder: one received byte in, one note/gate result out.
// A byte passes through the input register, then through the parser logic into the result
// register. Throughput: one byte per cycle unless out_ready stalls the result register.
// Both stages advance together whenever the result register is empty or taken.
// Reset (rst_n low, synchronous) empties both stages and clears parser state.
// Depends on mngd_pkg and mngd_parser.
module midi_note_gate_decoder
  import mngd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_note_code,
  output logic       out_note_strobe,
  output logic       out_gate_level,
  output logic       out_led_level
);

  // Input register. It holds one byte until the result register can take
  // the parser's answer for it.
  logic         in_vld_r;
  logic [7:0]   in_byte_r;
  // Result register.
  logic         out_vld_r;
  mngd_result_t out_res_r;

  logic         advance;
  logic         step;
  mngd_result_t parse_res;

  // The pipeline moves when the result slot is free or is being taken this
  // cycle. The parser state only changes when a byte really moves into the
  // result register, so stalls never double-count a byte.
  assign advance  = !out_vld_r || out_ready;
  assign step     = advance && in_vld_r;
  assign in_ready = !in_vld_r || advance;

  mngd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .result  (parse_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
    if (step) begin
      out_res_r <= parse_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_note_code   = out_res_r.note_code;
  assign out_note_strobe = out_res_r.note_strobe;
  assign out_gate_level  = out_res_r.gate_level;
  assign out_led_level   = out_res_r.led_level;

endmodule
